### design/gcml_pkg.sv
package gcml_pkg;

    // field and register widths
    localparam int DIM_W      = 13;  // image extent, cell size, divider width
    localparam int PIX_W      = 12;  // pixel coordinate
    localparam int GRID_W     = 5;   // column and row counts
    localparam int COUNT_W    = 8;   // per-cell count and limit
    localparam int CIDX_W     = 8;   // cell index on the output
    localparam int PROD_W     = 2 * GRID_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_CELL = 3'd4;

    // register reset values
    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [GRID_W-1:0]  RST_GRID_COLUMNS = 5'd8;
    localparam logic [GRID_W-1:0]  RST_GRID_ROWS    = 5'd8;
    localparam logic [COUNT_W-1:0] RST_MAX_PER_CELL = 8'd4;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic start_size;
        logic save_size;
        logic start_pos;
        logic calc_index;
        logic read_count;
        logic update;
    } gcml_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic geom_ok;
        logic div_busy;
        logic out_full;
    } gcml_stat_t;

endpackage

### design/gcml_ram.sv
module gcml_ram
    #(
        parameter int WIDTH = 8,
        parameter int DEPTH = 256,
        parameter int ADDR_W = 8
    )
    (
        input  logic              clk,
        input  logic              we,
        input  logic [ADDR_W-1:0] waddr,
        input  logic [WIDTH-1:0]  wdata,
        input  logic              re,
        input  logic [ADDR_W-1:0] raddr,
        output logic [WIDTH-1:0]  rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/gcml_div.sv
// restoring divider, one quotient bit per cycle
module gcml_div
    #(
        parameter int W = 13
    )
    (
        input  logic         clk,
        input  logic         rst_n,
        input  logic         start,
        input  logic [W-1:0] dividend,
        input  logic [W-1:0] divisor,
        output logic         busy,
        output logic [W-1:0] quotient
    );

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [W:0]       trial;
    logic [W:0]       diff;
    logic             fits;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[W-1:0] : trial[W-1:0];
            quo_next  = {quo_reg[W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### design/gcml_dp.sv
module gcml_dp
    import gcml_pkg::*;
    #(
        parameter int MAX_GRID_ROWS = 16,
        parameter int MAX_GRID_COLS = 16
    )
    (
        input  logic                  clk,
        input  logic                  rst_n,
        input  logic                  cfg_we,
        input  logic [CFG_IDX_W-1:0]  cfg_index,
        input  logic [CFG_DATA_W-1:0] cfg_data,
        input  logic [23:0]           s_tdata,
        input  logic                  s_tuser,
        output logic                  m_tvalid,
        input  logic                  m_tready,
        output logic [CIDX_W-1:0]     m_tdata,
        output logic                  m_tuser,
        input  gcml_cmd_t             cmd,
        output gcml_stat_t            stat
    );

    localparam int CELL_TOTAL = MAX_GRID_ROWS * MAX_GRID_COLS;
    localparam int IDX_W      = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;

    // configuration registers
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [GRID_W-1:0]  cols_cfg_reg;
    logic [GRID_W-1:0]  rows_cfg_reg;
    logic [COUNT_W-1:0] max_reg;
    logic               dirty_reg;

    // cell geometry and current item
    logic [DIM_W-1:0]   cw_reg;
    logic [DIM_W-1:0]   ch_reg;
    logic [PIX_W-1:0]   px_reg;
    logic [PIX_W-1:0]   py_reg;
    logic [PROD_W-1:0]  lin_reg, lin_next;
    logic [CELL_TOTAL-1:0] valid_reg;

    // output register
    logic               out_valid_reg;
    logic               keep_reg;
    logic [CIDX_W-1:0]  cidx_reg;

    logic [GRID_W-1:0]  cols, rows;
    logic [GRID_W-1:0]  col, row;
    logic [DIM_W-1:0]   dx_dvd, dx_dsr, dy_dvd, dy_dsr;
    logic               div_start;
    logic               bx, by;
    logic [DIM_W-1:0]   qx, qy;
    logic [IDX_W-1:0]   addr;
    logic [COUNT_W-1:0] rdata;
    logic [COUNT_W-1:0] cur;
    logic               keep;

    // effective column and row counts
    always_comb
    begin
        if (cols_cfg_reg == '0)
            cols = GRID_W'(1);
        else if (int'(cols_cfg_reg) > MAX_GRID_COLS)
            cols = GRID_W'(MAX_GRID_COLS);
        else
            cols = cols_cfg_reg;
        if (rows_cfg_reg == '0)
            rows = GRID_W'(1);
        else if (int'(rows_cfg_reg) > MAX_GRID_ROWS)
            rows = GRID_W'(MAX_GRID_ROWS);
        else
            rows = rows_cfg_reg;
    end

    // both dividers serve cell sizing and point placement
    assign div_start = cmd.start_size | cmd.start_pos;
    assign dx_dvd    = cmd.start_size ? width_reg  : {1'b0, px_reg};
    assign dx_dsr    = cmd.start_size ? DIM_W'(cols) : cw_reg;
    assign dy_dvd    = cmd.start_size ? height_reg : {1'b0, py_reg};
    assign dy_dsr    = cmd.start_size ? DIM_W'(rows) : ch_reg;

    gcml_div #(.W(DIM_W)) u_div_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dx_dvd),
        .divisor  (dx_dsr),
        .busy     (bx),
        .quotient (qx)
    );

    gcml_div #(.W(DIM_W)) u_div_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dy_dvd),
        .divisor  (dy_dsr),
        .busy     (by),
        .quotient (qy)
    );

    // clamp into the last column and row, then linear cell number
    always_comb
    begin
        col = (qx > DIM_W'(cols - 1'b1)) ? cols - 1'b1 : qx[GRID_W-1:0];
        row = (qy > DIM_W'(rows - 1'b1)) ? rows - 1'b1 : qy[GRID_W-1:0];
        lin_next = PROD_W'(row) * PROD_W'(cols) + PROD_W'(col);
    end

    assign addr = IDX_W'(lin_reg);

    gcml_ram #(.WIDTH(COUNT_W), .DEPTH(CELL_TOTAL), .ADDR_W(IDX_W)) u_counts
    (
        .clk   (clk),
        .we    (cmd.update & keep),
        .waddr (addr),
        .wdata (cur + 1'b1),
        .re    (cmd.read_count),
        .raddr (addr),
        .rdata (rdata)
    );

    assign cur  = valid_reg[addr] ? rdata : '0;
    assign keep = cur < max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= RST_IMAGE_WIDTH;
            height_reg    <= RST_IMAGE_HEIGHT;
            cols_cfg_reg  <= RST_GRID_COLUMNS;
            rows_cfg_reg  <= RST_GRID_ROWS;
            max_reg       <= RST_MAX_PER_CELL;
            dirty_reg     <= 1'b1;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg <= cfg_data[DIM_W-1:0];
                if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg <= cfg_data[DIM_W-1:0];
                if (cfg_index == REG_GRID_COLUMNS)
                    cols_cfg_reg <= cfg_data[GRID_W-1:0];
                if (cfg_index == REG_GRID_ROWS)
                    rows_cfg_reg <= cfg_data[GRID_W-1:0];
                if (cfg_index == REG_MAX_PER_CELL)
                    max_reg <= cfg_data[COUNT_W-1:0];
                if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
                    cfg_index == REG_GRID_COLUMNS || cfg_index == REG_GRID_ROWS)
                    dirty_reg <= 1'b1;
            end
            else if (cmd.save_size)
            begin
                dirty_reg <= 1'b0;
            end

            // set start wipes all counts before its own point
            if (cmd.load_item && s_tuser)
                valid_reg <= '0;
            else if (cmd.update && keep)
                valid_reg[addr] <= 1'b1;

            if (cmd.update)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            px_reg <= s_tdata[PIX_W-1:0];
            py_reg <= s_tdata[2*PIX_W-1:PIX_W];
        end
        if (cmd.save_size)
        begin
            cw_reg <= (qx == '0) ? DIM_W'(1) : qx;
            ch_reg <= (qy == '0) ? DIM_W'(1) : qy;
        end
        if (cmd.calc_index)
            lin_reg <= lin_next;
        if (cmd.update)
        begin
            keep_reg <= keep;
            cidx_reg <= CIDX_W'(lin_reg);
        end
    end

    assign stat.geom_ok  = ~dirty_reg;
    assign stat.div_busy = bx | by;
    assign stat.out_full = out_valid_reg & ~m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = keep_reg;
    assign m_tdata  = cidx_reg;

    // a result never overwrites one that is still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !(out_valid_reg && !m_tready))
        else $error("result register overwritten while stalled");

    // placement only runs on up-to-date cell sizes
    a_geom_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_pos |-> !dirty_reg && !bx && !by)
        else $error("placement started on stale geometry or busy divider");

    // the two dividers always run in lockstep
    a_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        bx == by)
        else $error("dividers out of step");

    // a kept point leaves its cell marked in use
    a_keep_marks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && keep && !cmd.load_item |=> valid_reg[$past(addr)])
        else $error("kept point did not mark its cell");

endmodule

### design/gcml_ctrl.sv
module gcml_ctrl
    import gcml_pkg::*;
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       s_tvalid,
        output logic       s_tready,
        input  gcml_stat_t stat,
        output gcml_cmd_t  cmd
    );

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_SIZE,
        ST_POS,
        ST_READ,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_item = s_tvalid;
                if (s_tvalid)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                if (stat.geom_ok)
                begin
                    cmd.start_pos = 1'b1;
                    state_next    = ST_POS;
                end
                else
                begin
                    cmd.start_size = 1'b1;
                    state_next     = ST_SIZE;
                end
            end
            ST_SIZE:
            begin
                if (!stat.div_busy)
                begin
                    cmd.save_size = 1'b1;
                    state_next    = ST_PREP;
                end
            end
            ST_POS:
            begin
                if (!stat.div_busy)
                begin
                    cmd.calc_index = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read_count = 1'b1;
                state_next     = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!stat.out_full)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

### design/grid_cell_match_limiter.sv
// grid cell match limiter
//
// input stream (s_*): one point match per item; s_tdata carries pixel_x in
// bits 11:0 and pixel_y in bits 23:12, s_tuser carries start_of_set, which
// clears all cell counts before the point is handled
// output stream (m_*): exactly one result per item; m_tdata is the cell index,
// m_tuser is keep (point passed the per-cell limit and was counted)
// configuration: cfg_we writes cfg_data into register cfg_index (0 image width,
// 1 image height, 2 grid columns, 3 grid rows, 4 max per cell); write only idle
//
// placement: the 13-step iterative dividers place the point in its column and
// row; for the first item after reset or after a geometry write the same
// dividers first work out the cell width and height
// one item is in flight at a time; s_tready is high only between items
// reset clears all counts at once and loads the default registers, no wait
// a stalled m_tready holds the result in the output register; the next item
// may be taken and worked on, and waits before its result until the slot frees
module grid_cell_match_limiter
    import gcml_pkg::*;
    #(
        parameter int MAX_GRID_ROWS = 16,
        parameter int MAX_GRID_COLS = 16
    )
    (
        input  logic                  clk,
        input  logic                  rst_n,
        // configuration write port
        input  logic                  cfg_we,
        input  logic [CFG_IDX_W-1:0]  cfg_index,
        input  logic [CFG_DATA_W-1:0] cfg_data,
        // input stream
        input  logic                  s_tvalid,
        output logic                  s_tready,
        input  logic [23:0]           s_tdata,   // pixel_x [11:0], pixel_y [23:12]
        input  logic                  s_tuser,   // start_of_set
        // output stream
        output logic                  m_tvalid,
        input  logic                  m_tready,
        output logic [CIDX_W-1:0]     m_tdata,   // cell_index [7:0]
        output logic                  m_tuser    // keep
    );

    gcml_cmd_t  cmd;
    gcml_stat_t stat;

    // sequencing: accept, size cells if needed, place point, read-modify-write
    gcml_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // registers, dividers, count memory and output register
    gcml_dp
    #(
        .MAX_GRID_ROWS (MAX_GRID_ROWS),
        .MAX_GRID_COLS (MAX_GRID_COLS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import gcml_pkg::*;

    // grid limits the block is built with
    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;

    // register indexes the block does not decode, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

    // run limits
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;   // receiver stall long enough to back up the input
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 135;

    // one point match waiting to go out on the input stream
    typedef struct {
        bit               first;    // start of a new set
        bit [PIX_W-1:0]   x;
        bit [PIX_W-1:0]   y;
    } point_t;

    // expected outcome of one point
    typedef struct {
        bit               keep;
        bit [CIDX_W-1:0]  cell_no;
    } placement_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata = '0;    // pixel_x [11:0], pixel_y [23:12]
    logic                  s_tuser = 1'b0;  // start_of_set
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [CIDX_W-1:0]     m_tdata;         // cell_index [7:0]
    logic                  m_tuser;         // keep

    grid_cell_match_limiter #(
        .MAX_GRID_ROWS (MAX_ROWS),
        .MAX_GRID_COLS (MAX_COLS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // shadow copy of the registers and the per-cell counts
    bit [DIM_W-1:0]   img_w       = RST_IMAGE_WIDTH;
    bit [DIM_W-1:0]   img_h       = RST_IMAGE_HEIGHT;
    bit [GRID_W-1:0]  col_setting = RST_GRID_COLUMNS;
    bit [GRID_W-1:0]  grid_rws    = RST_GRID_ROWS;
    bit [COUNT_W-1:0] cell_limit  = RST_MAX_PER_CELL;
    bit [COUNT_W-1:0] cell_fill [MAX_ROWS*MAX_COLS];

    point_t     points_to_send [$];
    placement_t predicted_cells [$];

    // handshake pacing shared between the stimulus and the two stream processes
    int  src_idle_pct  = 0;
    int  snk_idle_pct  = 0;
    bit  no_idle       = 1'b0;
    int  src_gap       = 0;
    int  snk_gap       = 0;
    bit  src_taken     = 1'b0;
    int  hold_requests = 0;
    int  holds_done    = 0;
    int  hold_left     = 0;

    int  error_count = 0;
    int  cycle_count = 0;

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // place one point on the grid, apply the per-cell limit and count it
    function automatic placement_t place_point(input bit first, input bit [PIX_W-1:0] x,
                                               input bit [PIX_W-1:0] y);
        int cols;
        int rows;
        int cw;
        int ch;
        int col;
        int row;
        int idx;
        placement_t res;
        // zero counts act as one, counts past the grid limit act as the limit
        cols = (col_setting == 0) ? 1 : ((col_setting > MAX_COLS) ? MAX_COLS : col_setting);
        rows = (grid_rws == 0) ? 1 : ((grid_rws > MAX_ROWS) ? MAX_ROWS : grid_rws);
        // an image narrower than the grid (or of zero size) gives one-pixel cells
        cw = img_w / cols;
        ch = img_h / rows;
        if (cw == 0)
            cw = 1;
        if (ch == 0)
            ch = 1;
        if (first)
        begin
            foreach (cell_fill[i])
                cell_fill[i] = '0;
        end
        // points past the last cell land in the last column or row
        col = x / cw;
        row = y / ch;
        if (col > cols - 1)
            col = cols - 1;
        if (row > rows - 1)
            row = rows - 1;
        idx = row * cols + col;
        res.cell_no = idx[CIDX_W-1:0];
        res.keep = 1'b0;
        if (idx < MAX_ROWS * MAX_COLS && cell_fill[idx] < cell_limit)
        begin
            cell_fill[idx] = cell_fill[idx] + 1'b1;
            res.keep = 1'b1;
        end
        return res;
    endfunction

    // register write on the config port, shadow copy follows along
    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (index)
            REG_IMAGE_WIDTH:  img_w       = value[DIM_W-1:0];
            REG_IMAGE_HEIGHT: img_h       = value[DIM_W-1:0];
            REG_GRID_COLUMNS: col_setting = value[GRID_W-1:0];
            REG_GRID_ROWS:    grid_rws    = value[GRID_W-1:0];
            REG_MAX_PER_CELL: cell_limit  = value[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_point(input bit first, input int x, input int y);
        point_t pt;
        pt.first = first;
        pt.x     = x[PIX_W-1:0];
        pt.y     = y[PIX_W-1:0];
        points_to_send = {points_to_send, pt};
    endtask

    // sender stops until every result is back, then the block is given time to settle
    task automatic drain;
        while (points_to_send.size() != 0 || predicted_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // image extent with the extremes weighted in
    function automatic int pick_extent();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 4096;
            3:       return 8191;
            default: return $urandom_range(16, 4096);
        endcase
    endfunction

    // column or row count, now and then outside the usable range
    function automatic int pick_count();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 31);
        return $urandom_range(1, 16);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 35;
        endcase
    endfunction

    // input stream driver: data changes on the falling edge
    always @(negedge clk)
    begin
        if (s_tvalid && !src_taken)
        begin
            // item still on offer, hold it
        end
        else if (src_gap > 0)
        begin
            src_gap  <= src_gap - 1;
            s_tvalid <= 1'b0;
        end
        else if (points_to_send.size() != 0 && !no_idle
                 && $urandom_range(0, 99) < src_idle_pct)
        begin
            // idle burst of random length
            src_gap  <= $urandom_range(0, 11);
            s_tvalid <= 1'b0;
        end
        else if (points_to_send.size() != 0)
        begin
            s_tvalid <= 1'b1;
            s_tdata  <= {points_to_send[0].y, points_to_send[0].x};
            s_tuser  <= points_to_send[0].first;
        end
        else
            s_tvalid <= 1'b0;
    end

    // input accept: predict from what the block actually took
    always @(posedge clk)
    begin
        src_taken <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            predicted_cells = {predicted_cells,
                               place_point(s_tuser, s_tdata[11:0], s_tdata[23:12])};
            void'(points_to_send.pop_front());
        end
    end

    // output ready: random stalls plus the long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else if (holds_done != hold_requests)
        begin
            holds_done <= holds_done + 1;
            hold_left  <= LONG_HOLD - 1;
            m_tready   <= 1'b0;
        end
        else if (snk_gap > 0)
        begin
            snk_gap  <= snk_gap - 1;
            m_tready <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 99) < snk_idle_pct)
        begin
            snk_gap  <= $urandom_range(0, 11);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result monitor: each item against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (predicted_cells.size() == 0)
            begin
                error_count <= error_count + 1;
                $display("%0t: unexpected item, expected none, actual cell %0d keep %0b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                if (m_tdata !== predicted_cells[0].cell_no
                    || m_tuser !== predicted_cells[0].keep)
                begin
                    error_count <= error_count + 1;
                    if (m_tdata !== predicted_cells[0].cell_no)
                        $display("%0t: cell index expected %0d actual %0d",
                                 $time, predicted_cells[0].cell_no, m_tdata);
                    if (m_tuser !== predicted_cells[0].keep)
                        $display("%0t: keep expected %0b actual %0b",
                                 $time, predicted_cells[0].keep, m_tuser);
                end
                void'(predicted_cells.pop_front());
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        int  n;
        int  k;
        int  set_len;
        int  span_x;
        int  span_y;
        int  hx;
        int  hy;
        int  px;
        int  py;
        int  pick;
        bit  first_set;

        foreach (cell_fill[i])
            cell_fill[i] = '0;

        // hold reset, then release it on a falling edge
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset geometry: 640 x 480 in 8 x 8 cells of 80 x 60, limit 4
        push_point(1, 0, 0);
        push_point(0, 4095, 4095);      // far corner, clamped into the last cell
        push_point(0, 4095, 0);
        push_point(0, 0, 4095);
        push_point(0, 639, 479);
        push_point(0, 5, 5);            // fill cell 0 up to the limit
        push_point(0, 5, 5);
        push_point(0, 5, 5);
        push_point(0, 5, 5);            // over the limit, dropped
        push_point(1, 5, 5);            // new set clears the counts
        push_point(0, 2730, 1365);      // alternating bit patterns
        drain();

        // tiny and zero-size image, zero rows, too many columns, limit of zero
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_GRID_COLUMNS, 31);
        write_reg(REG_GRID_ROWS, 0);
        write_reg(REG_MAX_PER_CELL, 0);
        push_point(1, 2, 0);
        push_point(0, 4095, 4095);
        drain();

        // largest image, full grid, highest limit
        write_reg(REG_IMAGE_WIDTH, 4096);
        write_reg(REG_IMAGE_HEIGHT, 4096);
        write_reg(REG_GRID_COLUMNS, 16);
        write_reg(REG_GRID_ROWS, 16);
        write_reg(REG_MAX_PER_CELL, 255);
        push_point(1, 4095, 4095);
        push_point(0, 255, 256);
        push_point(0, 256, 255);
        drain();

        // writes to undecoded indexes leave the geometry alone
        write_reg(REG_SPARE_LOW, 1);
        write_reg(REG_SPARE_HIGH, 8191);
        push_point(0, 4095, 4095);
        drain();

        // geometry changed inside a set, counts carry over
        write_reg(REG_GRID_COLUMNS, 1);
        write_reg(REG_IMAGE_WIDTH, 100);
        push_point(0, 4095, 4095);
        push_point(0, 0, 0);
        drain();

        // random phases, each with its own geometry and pacing
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == PHASES - 1)
            begin
                // last stretch runs without any idling
                no_idle      = 1'b1;
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            else
            begin
                src_idle_pct = pick_pct();
                snk_idle_pct = pick_pct();
            end

            write_reg(REG_IMAGE_WIDTH, pick_extent());
            write_reg(REG_IMAGE_HEIGHT, pick_extent());
            write_reg(REG_GRID_COLUMNS, pick_count());
            write_reg(REG_GRID_ROWS, pick_count());
            case ($urandom_range(0, 7))
                0:       write_reg(REG_MAX_PER_CELL, 0);
                1:       write_reg(REG_MAX_PER_CELL, 255);
                2:       write_reg(REG_MAX_PER_CELL, $urandom_range(9, 254));
                default: write_reg(REG_MAX_PER_CELL, $urandom_range(1, 6));
            endcase

            span_x = (img_w == 0) ? 1 : ((img_w > 4096) ? 4096 : img_w);
            span_y = (img_h == 0) ? 1 : ((img_h > 4096) ? 4096 : img_h);
            n = 0;
            first_set = 1'b1;
            while (n < PHASE_ITEMS)
            begin
                set_len = $urandom_range(1, 48);
                // hot spot so that some cells hit their limit
                hx = $urandom_range(0, span_x - 1);
                hy = $urandom_range(0, span_y - 1);
                for (k = 0; k < set_len && n < PHASE_ITEMS; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)
                    begin
                        px = hx + $urandom_range(0, 3);
                        py = hy + $urandom_range(0, 3);
                        if (px > 4095)
                            px = 4095;
                        if (py > 4095)
                            py = 4095;
                    end
                    else if (pick < 85)
                    begin
                        px = $urandom_range(0, span_x - 1);
                        py = $urandom_range(0, span_y - 1);
                    end
                    else
                    begin
                        px = $urandom_range(0, 4095);
                        py = $urandom_range(0, 4095);
                    end
                    // the first set of a phase sometimes carries on the old counts
                    push_point((k == 0) && !(first_set && $urandom_range(0, 9) < 3), px, py);
                    n++;
                    if (p == 5 && n == PHASE_ITEMS / 2)
                        drain();
                end
                first_set = 1'b0;
            end
            // receiver holds off while the sender keeps offering
            if (p == 2 || p == 9)
                hold_requests = hold_requests + 1;
            drain();
        end

        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
